[rtl/dam_pkg.sv]
// Shared constants and types for the difference-matte alpha key.
package dam_pkg;

    // Pixel geometry
    localparam int CHAN_W     = 8;
    localparam int NUM_CHAN   = 3;
    localparam int COVER_W    = 10;                 // coverage d in 0..765
    localparam int NUMER_W    = COVER_W + CHAN_W;   // black * 765 fits 18 bits
    localparam int SUM_W      = COVER_W + 2;        // signed channel-difference sum

    // Arithmetic constants
    localparam int FULL_COVER  = 765;
    localparam int MIN_COVER   = 3;
    localparam int RECIP_3     = 683;               // ceil(2^11 / 3)
    localparam int RECIP_SHIFT = 11;
    localparam int RECIP_W     = COVER_W + RECIP_SHIFT - 1;

    // One restoring-divider step per stage, one quotient bit each
    localparam int DIV_STAGES = CHAN_W;
    localparam int PIPE_STG   = DIV_STAGES + 1;     // front stage plus divider stages

    // Stream widths
    localparam int IN_DATA_W  = 2 * NUM_CHAN * CHAN_W;
    localparam int OUT_DATA_W = (NUM_CHAN + 1) * CHAN_W;

    typedef logic [CHAN_W-1:0]  chan_t;
    typedef logic [COVER_W-1:0] cover_t;
    typedef logic [NUMER_W-1:0] numer_t;

    // Per-pixel sideband that travels beside the lane dividers
    typedef struct packed {
        chan_t alpha;
        logic  low_cover;
        logic  last;
    } dam_side_t;

endpackage

[rtl/difference_matte_alpha_key.sv]
// Top level of the difference-matte alpha key stream block.
//
// Takes one pixel per beat as captured over a black and over a white
// backdrop and returns straight-alpha RGBA: alpha = floor(d / 3) with
// d = 765 - max(0, sum(white - black)), and each color channel
// min(255, floor(black * 765 / d)), forced to 0 when d <= 3. The block
// accepts one beat every clock unless a stall on m_tready backs up the pipe;
// each result passes in order through one front stage that forms d, alpha
// and the dividends, eight stages of the per-channel restoring dividers
// (one quotient bit each, three lanes side by side), and the output register.
// Each stage holds while the stage after it is full and stalled, so bubbles
// are squeezed out and input beats keep coming in while a finished result
// waits for m_tready.
// tlast is carried through unchanged.
module difference_matte_alpha_key import dam_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // s_tdata: black_red, black_green, black_blue, white_red, white_green,
    //          white_blue (8 bits each, from bit 0 up)
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tlast,
    // m_tdata: out_red, out_green, out_blue, out_alpha (8 bits each, from bit 0 up)
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tlast
);

    logic [PIPE_STG-1:0]             vld_reg;
    logic [PIPE_STG-1:0]             load;
    logic                            merge_ready;

    logic [NUM_CHAN-1:0][CHAN_W-1:0] blk;
    logic [NUM_CHAN-1:0][CHAN_W-1:0] wht;
    numer_t [NUM_CHAN-1:0]           front_numer;
    cover_t                          front_cover;
    dam_side_t                       front_side;
    dam_side_t                       side_reg [DIV_STAGES];
    chan_t [NUM_CHAN-1:0]            lane_quo;

    // Unpack the input beat
    always_comb begin
        for (int c = 0; c < NUM_CHAN; c++) begin
            blk[c] = s_tdata[c*CHAN_W +: CHAN_W];
            wht[c] = s_tdata[(NUM_CHAN+c)*CHAN_W +: CHAN_W];
        end
    end

    // A stage loads when it is empty or its content moves on
    always_comb begin
        load[PIPE_STG-1] = !vld_reg[PIPE_STG-1] || merge_ready;
        for (int i = PIPE_STG-2; i >= 0; i--) begin
            load[i] = !vld_reg[i] || load[i+1];
        end
    end

    assign s_tready = load[0];

    // Stage valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (load[0]) begin
                vld_reg[0] <= s_tvalid;
            end
            for (int i = 1; i < PIPE_STG; i++) begin
                if (load[i]) begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    dam_front u_front (
        .aclk     (aclk),
        .load     (load[0]),
        .blk      (blk),
        .wht      (wht),
        .last     (s_tlast),
        .numer    (front_numer),
        .coverage (front_cover),
        .side     (front_side)
    );

    for (genvar c = 0; c < NUM_CHAN; c++) begin : g_lane
        dam_lane u_lane (
            .aclk     (aclk),
            .load     (load[PIPE_STG-1:1]),
            .numer    (front_numer[c]),
            .coverage (front_cover),
            .quo      (lane_quo[c])
        );
    end

    // Sideband delay line matching the divider stages
    always_ff @(posedge aclk) begin
        if (load[1]) begin
            side_reg[0] <= front_side;
        end
        for (int k = 1; k < DIV_STAGES; k++) begin
            if (load[k+1]) begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    dam_merge u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (vld_reg[PIPE_STG-1]),
        .in_ready (merge_ready),
        .quo      (lane_quo),
        .side     (side_reg[DIV_STAGES-1]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // An empty output register means the whole pipe can move
    a_ready_when_out_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output register");

    // Zero alpha only comes from low coverage, which blanks the color
    a_zero_alpha_blank: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[NUM_CHAN*CHAN_W +: CHAN_W] == '0)
            |-> (m_tdata[NUM_CHAN*CHAN_W-1:0] == '0))
        else $error("color not blanked at zero alpha");

    // An accepted beat lands in the front stage
    a_accept_fills_front: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> vld_reg[0])
        else $error("accepted beat lost at front stage");

endmodule

[rtl/dam_front.sv]
// Front stage: coverage, alpha and per-channel dividends for one pixel.
module dam_front import dam_pkg::*; (
    input  logic                               aclk,
    input  logic                               load,
    input  logic [NUM_CHAN-1:0][CHAN_W-1:0]    blk,
    input  logic [NUM_CHAN-1:0][CHAN_W-1:0]    wht,
    input  logic                               last,
    output numer_t [NUM_CHAN-1:0]              numer,
    output cover_t                             coverage,
    output dam_side_t                          side
);

    logic signed [SUM_W-1:0] diff_sum;
    logic signed [SUM_W-1:0] cover_wide;
    cover_t                  cover_next;
    logic [RECIP_W-1:0]      alpha_prod;
    dam_side_t               side_next;
    numer_t [NUM_CHAN-1:0]   numer_next;

    numer_t [NUM_CHAN-1:0]   numer_reg;
    cover_t                  cover_reg;
    dam_side_t               side_reg;

    // Signed sum of white minus black, clamped at zero, gives d = 765 - s
    always_comb begin
        diff_sum = '0;
        for (int c = 0; c < NUM_CHAN; c++) begin
            diff_sum = diff_sum + $signed({{(SUM_W-CHAN_W){1'b0}}, wht[c]})
                                - $signed({{(SUM_W-CHAN_W){1'b0}}, blk[c]});
        end
        cover_wide = diff_sum[SUM_W-1] ? SUM_W'(FULL_COVER)
                                       : SUM_W'(FULL_COVER) - diff_sum;
        cover_next = cover_wide[COVER_W-1:0];
    end

    // Alpha = floor(d / 3) by reciprocal multiply; exact for d <= 765
    always_comb begin
        alpha_prod            = RECIP_W'(cover_next) * RECIP_W'(RECIP_3);
        side_next.alpha       = alpha_prod[RECIP_SHIFT +: CHAN_W];
        side_next.low_cover   = (cover_next <= COVER_W'(MIN_COVER));
        side_next.last        = last;
        for (int c = 0; c < NUM_CHAN; c++) begin
            numer_next[c] = NUMER_W'(blk[c]) * NUMER_W'(FULL_COVER);
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            numer_reg <= numer_next;
            cover_reg <= cover_next;
            side_reg  <= side_next;
        end
    end

    assign numer    = numer_reg;
    assign coverage = cover_reg;
    assign side     = side_reg;

endmodule

[rtl/dam_lane.sv]
// One color lane: pipelined restoring divider, black*765 / d saturated at 255.
module dam_lane import dam_pkg::*; (
    input  logic                  aclk,
    input  logic [DIV_STAGES-1:0] load,
    input  numer_t                numer,
    input  cover_t                coverage,
    output chan_t                 quo
);

    numer_t rem_reg [DIV_STAGES];
    cover_t cov_reg [DIV_STAGES];
    chan_t  quo_reg [DIV_STAGES];
    logic   ovf_reg [DIV_STAGES];

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_step
        localparam int QBIT = DIV_STAGES - 1 - k;

        numer_t rem_in;
        cover_t cov_in;
        chan_t  quo_in;
        logic   ovf_in;
        numer_t trial;
        logic   take;
        numer_t rem_next;
        chan_t  quo_next;

        // First step also flags a quotient that does not fit in a byte
        if (k == 0) begin : g_first
            always_comb begin
                rem_in = numer;
                cov_in = coverage;
                quo_in = '0;
                ovf_in = (numer >= NUMER_W'({coverage, CHAN_W'(0)}));
            end
        end else begin : g_next
            always_comb begin
                rem_in = rem_reg[k-1];
                cov_in = cov_reg[k-1];
                quo_in = quo_reg[k-1];
                ovf_in = ovf_reg[k-1];
            end
        end

        // Trial subtract of d shifted to this quotient bit
        always_comb begin
            trial          = NUMER_W'(cov_in) << QBIT;
            take           = (rem_in >= trial);
            rem_next       = take ? (rem_in - trial) : rem_in;
            quo_next       = quo_in;
            quo_next[QBIT] = take;
        end

        always_ff @(posedge aclk) begin
            if (load[k]) begin
                rem_reg[k] <= rem_next;
                cov_reg[k] <= cov_in;
                quo_reg[k] <= quo_next;
                ovf_reg[k] <= ovf_in;
            end
        end
    end

    // Saturate at full scale
    assign quo = ovf_reg[DIV_STAGES-1] ? '1 : quo_reg[DIV_STAGES-1];

endmodule

[rtl/dam_merge.sv]
// Merge stage: joins lane quotients and sideband into the output register.
module dam_merge import dam_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  chan_t [NUM_CHAN-1:0]    quo,
    input  dam_side_t               side,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [OUT_DATA_W-1:0]   m_tdata,
    output logic                    m_tlast
);

    logic                  out_vld_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic                  out_last_reg;
    logic [OUT_DATA_W-1:0] out_data_next;

    assign in_ready = !out_vld_reg || m_tready;

    // Low coverage blanks the color; alpha goes in the top byte
    always_comb begin
        for (int c = 0; c < NUM_CHAN; c++) begin
            out_data_next[c*CHAN_W +: CHAN_W] = side.low_cover ? '0 : quo[c];
        end
        out_data_next[NUM_CHAN*CHAN_W +: CHAN_W] = side.alpha;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (in_ready) begin
            out_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            out_data_reg <= out_data_next;
            out_last_reg <= side.last;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule
